// ----- sv/keyed_fnv_verdict_seal_top_macros.svh -----
// ----------------------------------------------------------------------------
// keyed_fnv_verdict_seal_top_macros
// assertion helpers shared by the verdict seal block
// ----------------------------------------------------------------------------
`ifndef KEYED_FNV_VERDICT_SEAL_TOP_MACROS_SVH
`define KEYED_FNV_VERDICT_SEAL_TOP_MACROS_SVH

// same-cycle implication under active-low reset
`define KFVS_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under active-low reset
`define KFVS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/kfvs_pkg.sv -----
// ----------------------------------------------------------------------------
// kfvs_pkg
// types and constants of the keyed fnv-1a verdict seal block
// ----------------------------------------------------------------------------
`default_nettype none

package kfvs_pkg;

    localparam logic [63:0] FNV_BASIS      = 64'hCBF2_9CE4_8422_2325;
    // prime is 2^40 + 0x1b3
    localparam int          FNV_PRIME_SHIFT = 40;
    localparam logic [63:0] FNV_PRIME_LOW  = 64'h0000_0000_0000_01B3;
    localparam logic [31:0] MAX_AGE_RESET  = 32'd10000;

    localparam int KEY_BYTES = 32;
    localparam int REC_BYTES = 24;
    localparam int NUM_STEPS = 2 * KEY_BYTES + REC_BYTES;

    typedef logic [6:0] step_idx_t;

    localparam step_idx_t LAST_STEP = step_idx_t'(NUM_STEPS - 1);

    typedef logic [2:0] cfg_idx_t;

    localparam cfg_idx_t CFG_KEY_0   = 3'd0;
    localparam cfg_idx_t CFG_KEY_1   = 3'd1;
    localparam cfg_idx_t CFG_KEY_2   = 3'd2;
    localparam cfg_idx_t CFG_KEY_3   = 3'd3;
    localparam cfg_idx_t CFG_MAX_AGE = 3'd4;

    localparam logic FUNC_SEAL   = 1'b0;
    localparam logic FUNC_VERIFY = 1'b1;

    typedef logic [KEY_BYTES-1:0][7:0] key_bytes_t;
    typedef logic [REC_BYTES-1:0][7:0] rec_bytes_t;

    typedef struct packed {
        logic        func;
        logic [63:0] nonce;
        logic [31:0] verdict_flags;
        logic [31:0] verdict_score;
        logic [63:0] stamp_ms;
        logic [63:0] received_tag;
        logic [63:0] now_ms;
    } kfvs_in_t;

    typedef struct packed {
        logic [63:0] tag;
        logic        accepted;
        logic [31:0] flags_out;
        logic [31:0] verified_score;
    } kfvs_out_t;

    typedef struct packed {
        logic      load;
        logic      step;
        logic      out_load;
        step_idx_t byte_idx;
    } kfvs_cmd_t;

endpackage

`default_nettype wire

// ----- sv/keyed_fnv_verdict_seal_top.sv -----
// ----------------------------------------------------------------------------
// keyed_fnv_verdict_seal_top
// seals or checks a 24-byte verdict record with a keyed fnv-1a 64-bit tag
//
// s_ channel takes one request word (mode, record, tag to check, current
// time); m_ channel returns one result word (tag, pass bit, flags, score).
// the config port writes the four key words and the maximum age; the user
// must do so only while idle, as the block itself does not enforce it. one
// byte is absorbed per cycle: 32 key bytes, 24 record bytes, 32 key bytes
// reversed, all through the single fnv multiply step. a new word is taken
// only once the last one is finished; s_ready is high only between requests.
// a finished result sits in the output register while the next word is
// absorbed; if the receiver still stalls at the end of that word, the block
// holds there with s_ready low until the register frees.
// reset clears the sequencer and output valid, keys to zero, max age 10000.
// ----------------------------------------------------------------------------
`default_nettype none

`include "keyed_fnv_verdict_seal_top_macros.svh"

module keyed_fnv_verdict_seal_top
    import kfvs_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire cfg_idx_t    cfg_index,
    input  wire logic [63:0] cfg_wdata,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire kfvs_in_t    s_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output kfvs_out_t        m_data
);

    key_bytes_t  key;
    logic [31:0] max_age;
    kfvs_cmd_t   cmd;

    kfvs_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .key       (key),
        .max_age   (max_age)
    );

    kfvs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    kfvs_datapath u_dp (
        .aclk    (aclk),
        .cmd     (cmd),
        .s_data  (s_data),
        .key     (key),
        .max_age (max_age),
        .m_data  (m_data)
    );

    `KFVS_ASSERT_NEXT(a_busy_after_take, aclk, aresetn, s_valid && s_ready, !s_ready,
        "input taken while a word is in progress")
    `KFVS_ASSERT_SAME(a_fail_zeroes, aclk, aresetn, m_valid && !m_data.accepted,
        m_data.flags_out == 32'd0 && m_data.verified_score == 32'd0,
        "failed check returned flags or score")
    `KFVS_ASSERT_SAME(a_result_from_busy, aclk, aresetn, $rose(m_valid), !$past(s_ready),
        "result appeared without a word in progress")

endmodule

`default_nettype wire

// ----- sv/kfvs_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// kfvs_cfg_regs
// key and maximum age registers with write decode
// ----------------------------------------------------------------------------
`default_nettype none

module kfvs_cfg_regs
    import kfvs_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire cfg_idx_t    cfg_index,
    input  wire logic [63:0] cfg_wdata,
    output key_bytes_t       key,
    output logic [31:0]      max_age
);

    logic [63:0] key0_reg, key1_reg, key2_reg, key3_reg;
    logic [31:0] max_age_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key0_reg    <= '0;
            key1_reg    <= '0;
            key2_reg    <= '0;
            key3_reg    <= '0;
            max_age_reg <= MAX_AGE_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_KEY_0:   key0_reg    <= cfg_wdata;
                CFG_KEY_1:   key1_reg    <= cfg_wdata;
                CFG_KEY_2:   key2_reg    <= cfg_wdata;
                CFG_KEY_3:   key3_reg    <= cfg_wdata;
                CFG_MAX_AGE: max_age_reg <= cfg_wdata[31:0];
                default: ;
            endcase
        end
    end

    assign key     = {key3_reg, key2_reg, key1_reg, key0_reg};
    assign max_age = max_age_reg;

endmodule

`default_nettype wire

// ----- sv/kfvs_ctrl.sv -----
// ----------------------------------------------------------------------------
// kfvs_ctrl
// sequencer: takes a word, steps the byte counter, hands off the result
// ----------------------------------------------------------------------------
`default_nettype none

module kfvs_ctrl
    import kfvs_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  wire logic m_ready,
    output kfvs_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_ABSORB = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t    state_reg, state_next;
    step_idx_t cnt_reg, cnt_next;
    logic      out_valid_reg, out_valid_next;
    logic      out_load;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_ABSORB;
                    cnt_next   = '0;
                end
            end
            ST_ABSORB: begin
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == LAST_STEP) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!out_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = out_valid_reg;
    assign cmd.load     = s_ready && s_valid;
    assign cmd.step     = (state_reg == ST_ABSORB);
    assign cmd.out_load = out_load;
    assign cmd.byte_idx = cnt_reg;

endmodule

`default_nettype wire

// ----- sv/kfvs_datapath.sv -----
// ----------------------------------------------------------------------------
// kfvs_datapath
// word register, byte select, fnv-1a step, freshness check, result register
// ----------------------------------------------------------------------------
`default_nettype none

module kfvs_datapath
    import kfvs_pkg::*;
(
    input  wire logic        aclk,
    input  wire kfvs_cmd_t   cmd,
    input  wire kfvs_in_t    s_data,
    input  wire key_bytes_t  key,
    input  wire logic [31:0] max_age,
    output kfvs_out_t        m_data
);

    localparam step_idx_t REC_START  = step_idx_t'(KEY_BYTES);
    localparam step_idx_t TAIL_START = step_idx_t'(KEY_BYTES + REC_BYTES);
    localparam step_idx_t TAIL_TOP   = step_idx_t'(2 * KEY_BYTES + REC_BYTES - 1);

    function automatic logic [63:0] fnv_absorb(input logic [63:0] h, input logic [7:0] b);
        logic [63:0] x;
        x = h ^ {56'd0, b};
        return (x << FNV_PRIME_SHIFT) + (x * FNV_PRIME_LOW);
    endfunction

    kfvs_in_t    item_reg;
    logic [63:0] hash_reg, hash_next;
    logic [64:0] diff_reg;
    logic        fresh_reg;
    kfvs_out_t   out_reg, out_next;

    rec_bytes_t  rec;
    logic [4:0]  key_idx;
    logic [4:0]  rec_idx;
    logic [7:0]  cur_byte;
    logic        verify_ok;

    assign rec = {item_reg.stamp_ms, item_reg.verdict_score,
                  item_reg.verdict_flags, item_reg.nonce};

    always_comb begin
        if (cmd.byte_idx < REC_START) begin
            key_idx = cmd.byte_idx[4:0];
        end else begin
            key_idx = 5'(TAIL_TOP - cmd.byte_idx);
        end
        rec_idx = 5'(cmd.byte_idx - REC_START);
        if (cmd.byte_idx >= REC_START && cmd.byte_idx < TAIL_START) begin
            cur_byte = rec[rec_idx];
        end else begin
            cur_byte = key[key_idx];
        end
    end

    always_comb begin
        hash_next = hash_reg;
        if (cmd.load) begin
            hash_next = FNV_BASIS;
        end else if (cmd.step) begin
            hash_next = fnv_absorb(hash_reg, cur_byte);
        end
    end

    assign verify_ok = (hash_reg == item_reg.received_tag) && fresh_reg;

    always_comb begin
        out_next.tag = hash_reg;
        if (item_reg.func == FUNC_VERIFY) begin
            out_next.accepted       = verify_ok;
            out_next.flags_out      = verify_ok ? item_reg.verdict_flags : 32'd0;
            out_next.verified_score = verify_ok ? item_reg.verdict_score : 32'd0;
        end else begin
            out_next.accepted       = 1'b1;
            out_next.flags_out      = 32'd0;
            out_next.verified_score = 32'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_reg <= s_data;
        end
        hash_reg  <= hash_next;
        // the age difference is registered from the word register, then the freshness flag from the difference
        diff_reg  <= {1'b0, item_reg.now_ms} - {1'b0, item_reg.stamp_ms};
        fresh_reg <= !diff_reg[64] && (diff_reg[63:0] <= {32'd0, max_age});
        if (cmd.out_load) begin
            out_reg <= out_next;
        end
    end

    assign m_data = out_reg;

endmodule

`default_nettype wire

// ----- sim/tb_keyed_fnv_verdict_seal_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_keyed_fnv_verdict_seal_top
// self-checking bench for the keyed fnv-1a verdict seal block
//
// request words go in through the s_ channel with random gaps and the
// results are taken from the m_ channel under random stalls. every
// accepted request is run through a bench-side keyed fnv-1a tag and
// freshness predictor, and each result word is compared field by field
// against the oldest prediction. a short directed run covers reset
// values, field extremes, freshness edges, forged and tampered records
// and register writes; the bulk is random traffic over several key and
// max-age settings, written only while the block is drained.
// ----------------------------------------------------------------------------

module tb_keyed_fnv_verdict_seal_top;
    import kfvs_pkg::*;

    localparam logic [63:0] SEAL_BASIS      = 64'hCBF2_9CE4_8422_2325;
    localparam logic [63:0] SEAL_PRIME      = 64'h0000_0100_0000_01B3;
    localparam int          CFG_SLOTS       = 2 ** $bits(cfg_idx_t);
    localparam int          RANDOM_PHASES   = 6;
    localparam int          ITEMS_PER_PHASE = 285;
    localparam int          TAIL_CYCLES     = 200;
    localparam int unsigned RUN_LIMIT       = 3_000_000;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_wr_en;
    cfg_idx_t    cfg_index;
    logic [63:0] cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    kfvs_in_t    s_data;
    logic        m_valid;
    logic        m_ready;
    kfvs_out_t   m_data;

    logic [63:0] key_regs [4];
    logic [31:0] age_limit;
    kfvs_out_t   pending_verdicts [$];
    int unsigned fail_count  = 0;
    int unsigned cycle_count = 0;

    keyed_fnv_verdict_seal_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("[keyed_fnv_verdict_seal_top] ERROR");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // mostly short gaps, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 55) return 0;
        if (roll < 85) return $urandom_range(4, 1);
        if (roll < 97) return $urandom_range(40, 5);
        return $urandom_range(150, 60);
    endfunction

    function automatic logic [63:0] mix_byte(input logic [63:0] h, input logic [7:0] b);
        return (h ^ {56'd0, b}) * SEAL_PRIME;
    endfunction

    // key bytes forward, record bytes, key bytes backward
    function automatic logic [63:0] seal_tag(input logic [63:0] nonce,
                                             input logic [31:0] flags,
                                             input logic [31:0] score,
                                             input logic [63:0] stamp);
        logic [63:0]  h;
        logic [191:0] rec;
        h   = SEAL_BASIS;
        rec = {stamp, score, flags, nonce};
        for (int i = 0; i < 32; i++) h = mix_byte(h, key_regs[i / 8][8 * (i % 8) +: 8]);
        for (int i = 0; i < 24; i++) h = mix_byte(h, rec[8 * i +: 8]);
        for (int i = 31; i >= 0; i--) h = mix_byte(h, key_regs[i / 8][8 * (i % 8) +: 8]);
        return h;
    endfunction

    function automatic kfvs_out_t verdict_for(input kfvs_in_t w);
        kfvs_out_t r;
        logic      ok;
        r.tag = seal_tag(w.nonce, w.verdict_flags, w.verdict_score, w.stamp_ms);
        if (w.func == FUNC_SEAL) begin
            r.accepted       = 1'b1;
            r.flags_out      = '0;
            r.verified_score = '0;
        end else begin
            ok = (r.tag == w.received_tag) && (w.stamp_ms <= w.now_ms) &&
                 ((w.now_ms - w.stamp_ms) <= {32'd0, age_limit});
            r.accepted       = ok;
            r.flags_out      = ok ? w.verdict_flags : '0;
            r.verified_score = ok ? w.verdict_score : '0;
        end
        return r;
    endfunction

    function automatic kfvs_in_t verify_word(input logic [63:0] nonce,
                                             input logic [31:0] flags,
                                             input logic [31:0] score,
                                             input logic [63:0] stamp,
                                             input logic [63:0] now);
        kfvs_in_t w;
        w.func          = FUNC_VERIFY;
        w.nonce         = nonce;
        w.verdict_flags = flags;
        w.verdict_score = score;
        w.stamp_ms      = stamp;
        w.now_ms        = now;
        w.received_tag  = seal_tag(nonce, flags, score, stamp);
        return w;
    endfunction

    function automatic kfvs_in_t seal_word(input logic [63:0] nonce,
                                           input logic [31:0] flags,
                                           input logic [31:0] score,
                                           input logic [63:0] stamp);
        kfvs_in_t w;
        w              = verify_word(nonce, flags, score, stamp, rand64());
        w.func         = FUNC_SEAL;
        w.received_tag = rand64();
        return w;
    endfunction

    function automatic kfvs_in_t random_verdict_word();
        kfvs_in_t    w;
        logic [63:0] age;
        w.func          = ($urandom_range(99) < 35) ? FUNC_SEAL : FUNC_VERIFY;
        w.nonce         = rand64();
        w.verdict_flags = $urandom;
        w.verdict_score = $urandom;
        w.now_ms        = ($urandom_range(3) == 0) ? 64'($urandom_range(100000)) : rand64();
        case ($urandom_range(9))
            0:       age = '0;
            1:       age = {32'd0, age_limit};
            2:       age = {32'd0, age_limit} + 64'd1;
            3:       age = rand64();
            4:       age = '1;
            5:       age = ~{32'd0, $urandom};
            default: age = 64'($urandom_range(age_limit, 0));
        endcase
        w.stamp_ms = w.now_ms - age;
        if (w.func == FUNC_SEAL || $urandom_range(3) == 0)
            w.received_tag = rand64();
        else
            w.received_tag = seal_tag(w.nonce, w.verdict_flags, w.verdict_score, w.stamp_ms);
        // tampered record or tag
        if (w.func == FUNC_VERIFY && $urandom_range(9) == 0) begin
            case ($urandom_range(4))
                0:       w.nonce         ^= 64'd1 << $urandom_range(63);
                1:       w.verdict_flags ^= 32'd1 << $urandom_range(31);
                2:       w.verdict_score ^= 32'd1 << $urandom_range(31);
                3:       w.stamp_ms      ^= 64'd1 << $urandom_range(63);
                default: w.received_tag  ^= 64'd1 << $urandom_range(63);
            endcase
        end
        return w;
    endfunction

    task automatic flag_error(input string msg);
        fail_count++;
        if (fail_count <= 10) $display("%s", msg);
    endtask

    // newest prediction goes to the tail
    task automatic append_verdict(input kfvs_out_t r);
        pending_verdicts.insert(pending_verdicts.size(), r);
    endtask

    // a zero gap leaves valid high for the next word
    task automatic send_word(input kfvs_in_t w, input int unsigned gap);
        s_data  <= w;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        append_verdict(verdict_for(w));
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge aclk);
        @(posedge aclk);
    endtask

    task automatic cfg_write(input cfg_idx_t idx, input logic [63:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        case (idx)
            CFG_KEY_0, CFG_KEY_1, CFG_KEY_2, CFG_KEY_3: key_regs[idx[1:0]] = val;
            CFG_MAX_AGE: age_limit = val[31:0];
            default: ;
        endcase
    endtask

    always @(posedge aclk) begin : result_check
        kfvs_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_verdicts.size() == 0) begin
                flag_error($sformatf("unexpected result word: tag %h accepted %b",
                                     m_data.tag, m_data.accepted));
            end else begin
                want = pending_verdicts.pop_front();
                if (m_data.tag !== want.tag)
                    flag_error($sformatf("tag mismatch: expected %h, got %h",
                                         want.tag, m_data.tag));
                if (m_data.accepted !== want.accepted)
                    flag_error($sformatf("accepted mismatch: expected %b, got %b",
                                         want.accepted, m_data.accepted));
                if (m_data.flags_out !== want.flags_out)
                    flag_error($sformatf("flags_out mismatch: expected %h, got %h",
                                         want.flags_out, m_data.flags_out));
                if (m_data.verified_score !== want.verified_score)
                    flag_error($sformatf("verified_score mismatch: expected %h, got %h",
                                         want.verified_score, m_data.verified_score));
            end
        end
    end

    initial begin : result_ready_gen
        int unsigned hold;
        int unsigned stall;
        forever begin
            m_ready <= 1'b1;
            hold = ($urandom_range(9) == 0) ? $urandom_range(3000, 500) : $urandom_range(20, 1);
            repeat (hold) @(posedge aclk);
            stall = pick_gap();
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
        end
    end

    task automatic test_reset_defaults();
        send_word(seal_word('0, '0, '0, '0), pick_gap());
        send_word(seal_word('1, '1, '1, '1), pick_gap());
        send_word(verify_word(rand64(), $urandom, $urandom, 64'd1000, 64'd11000), pick_gap());
        send_word(verify_word(rand64(), $urandom, $urandom, 64'd1000, 64'd11001), pick_gap());
    endtask

    task automatic test_field_extremes();
        kfvs_in_t w;
        send_word(verify_word('1, '1, '1, '1, '1), pick_gap());
        send_word(verify_word('0, '0, '0, '0, '0), pick_gap());
        w              = seal_word('1, '0, '1, '0);
        w.received_tag = '1;
        w.now_ms       = '1;
        send_word(w, pick_gap());
        w              = verify_word('0, '1, '0, 64'd5, 64'd5);
        w.received_tag = ~w.received_tag;
        send_word(w, pick_gap());
    endtask

    task automatic test_freshness_edges();
        kfvs_in_t    w;
        logic [63:0] t;
        t = rand64() >> 1;
        send_word(verify_word(rand64(), $urandom, $urandom, t, t), pick_gap());
        // stamp in the future by one
        send_word(verify_word(rand64(), $urandom, $urandom, t + 64'd1, t), pick_gap());
        w              = verify_word(rand64(), $urandom, $urandom, t - 64'd3, t);
        w.received_tag ^= 64'd1 << $urandom_range(63);
        send_word(w, pick_gap());
        w               = verify_word(rand64(), $urandom, $urandom, t - 64'd3, t);
        w.verdict_flags ^= 32'd1 << $urandom_range(31);
        send_word(w, pick_gap());
    endtask

    task automatic test_register_writes();
        logic [63:0] pattern;
        wait_drained();
        for (int k = 0; k < 4; k++) cfg_write(cfg_idx_t'(CFG_KEY_0 + k), '1);
        send_word(seal_word('1, '1, '1, '1), pick_gap());
        send_word(verify_word(rand64(), $urandom, $urandom, 64'd7, 64'd9), pick_gap());

        // distinct byte per key position to catch byte order
        wait_drained();
        for (int k = 0; k < 4; k++) begin
            for (int b = 0; b < 8; b++) pattern[8 * b +: 8] = 8'(8 * k + b);
            cfg_write(cfg_idx_t'(CFG_KEY_0 + k), pattern);
        end
        send_word(seal_word(rand64(), $urandom, $urandom, rand64()), pick_gap());

        // indexes past the register list are ignored
        wait_drained();
        for (int i = CFG_MAX_AGE + 1; i < CFG_SLOTS; i++) cfg_write(cfg_idx_t'(i), '1);
        send_word(seal_word(rand64(), $urandom, $urandom, rand64()), pick_gap());
        send_word(verify_word(rand64(), $urandom, $urandom, 64'd500, 64'd10500), pick_gap());

        // upper data bits dropped on the age register
        wait_drained();
        cfg_write(CFG_MAX_AGE, 64'hFFFF_FFFF_0000_0005);
        send_word(verify_word(rand64(), $urandom, $urandom, 64'd100, 64'd105), pick_gap());
        send_word(verify_word(rand64(), $urandom, $urandom, 64'd100, 64'd106), pick_gap());

        wait_drained();
        cfg_write(CFG_MAX_AGE, 64'd0);
        send_word(verify_word(rand64(), $urandom, $urandom, 64'd42, 64'd42), pick_gap());
        send_word(verify_word(rand64(), $urandom, $urandom, 64'd42, 64'd43), pick_gap());
        send_word(verify_word(rand64(), $urandom, $urandom, 64'd0, 64'h1_0000_0000), pick_gap());

        wait_drained();
        cfg_write(CFG_MAX_AGE, 64'hFFFF_FFFF);
        send_word(verify_word(rand64(), $urandom, $urandom, 64'd1, 64'h1_0000_0000), pick_gap());
        send_word(verify_word(rand64(), $urandom, $urandom, 64'd0, 64'h1_0000_0000), pick_gap());
        send_word(verify_word(rand64(), $urandom, $urandom, 64'd0, '1), pick_gap());
    endtask

    task automatic test_random_traffic();
        int unsigned calm_left;
        int unsigned gap;
        logic [31:0] age_pick;
        calm_left = 0;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_drained();
            for (int k = 0; k < 4; k++)
                cfg_write(cfg_idx_t'(CFG_KEY_0 + k), (phase == 1) ? '1 : rand64());
            case (phase)
                0:       age_pick = 32'd0;
                1:       age_pick = 32'hFFFF_FFFF;
                2:       age_pick = $urandom_range(64, 1);
                3:       age_pick = MAX_AGE_RESET;
                default: age_pick = $urandom;
            endcase
            cfg_write(CFG_MAX_AGE, {$urandom, age_pick});
            cfg_write(cfg_idx_t'($urandom_range(CFG_SLOTS - 1, CFG_MAX_AGE + 1)), rand64());
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if ($urandom_range(99) == 0) wait_drained();
                if (calm_left != 0) begin
                    gap = 0;
                    calm_left--;
                end else begin
                    gap = pick_gap();
                    if ($urandom_range(19) == 0) calm_left = $urandom_range(40, 10);
                end
                send_word(random_verdict_word(), gap);
            end
        end
    endtask

    initial begin
        aresetn   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= CFG_KEY_0;
        cfg_wdata <= '0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        for (int k = 0; k < 4; k++) key_regs[k] = '0;
        age_limit = MAX_AGE_RESET;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_field_extremes();
        test_freshness_edges();
        test_register_writes();
        test_random_traffic();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending_verdicts.size() == 0) begin
            $display("[keyed_fnv_verdict_seal_top] OK");
        end else begin
            $display("[keyed_fnv_verdict_seal_top] ERROR");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/kfvs_pkg.sv
sv/kfvs_cfg_regs.sv
sv/kfvs_ctrl.sv
sv/kfvs_datapath.sv
sv/keyed_fnv_verdict_seal_top.sv
sim/tb_keyed_fnv_verdict_seal_top.sv
